/* rtl/core/tonego_pkg.sv */
// ----------------------------------------------------------------------------
// tonego_pkg
// Shared types and constants for the telnet option negotiator: beat formats,
// the classified command passed from front to back, and the table entry.
// ----------------------------------------------------------------------------
package tonego_pkg;

   // number of option codes kept in the tables (2 to 256)
   localparam int OPTION_COUNT = 256;
   localparam int OPT_NUM_W    = 8;
   localparam int OPT_IDX_W    = (OPTION_COUNT > 1) ? $clog2(OPTION_COUNT) : 1;

   // command queue between front and back
   localparam int QUEUE_DEPTH  = 2;
   localparam int QPTR_W       = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int QCNT_W       = $clog2(QUEUE_DEPTH + 1);

   typedef enum logic [3:0] {
      OP_RX_DO       = 4'd0,
      OP_RX_DONT     = 4'd1,
      OP_RX_WILL     = 4'd2,
      OP_RX_WONT     = 4'd3,
      OP_ASK_WILL    = 4'd4,
      OP_ASK_WONT    = 4'd5,
      OP_ASK_DO      = 4'd6,
      OP_ASK_DONT    = 4'd7,
      OP_SET_SUPPORT = 4'd8
   } opcode_type;

   typedef enum logic [1:0] {
      CMD_WILL = 2'd0,
      CMD_WONT = 2'd1,
      CMD_DO   = 2'd2,
      CMD_DONT = 2'd3
   } send_cmd_type;

   typedef enum logic [2:0] {
      NS_NONE     = 3'd0,
      NS_NO       = 3'd1,
      NS_YES      = 3'd2,
      NS_WANT_NO  = 3'd3,
      NS_WANT_YES = 3'd4
   } neg_state_type;

   typedef enum logic [1:0] {
      K_NOP     = 2'd0,
      K_RX      = 2'd1,
      K_ASK     = 2'd2,
      K_SUPPORT = 2'd3
   } cmd_kind_type;

   typedef enum logic {
      BK_IDLE = 1'b0,
      BK_EXEC = 1'b1
   } back_state_type;

   typedef struct packed {
      logic [3:0]           opcode;
      logic [OPT_NUM_W-1:0] option_number;
      logic                 handler_accepts;
      logic                 support_value;
   } req_type;

   typedef struct packed {
      logic                 send_valid;
      logic [1:0]           send_command;
      logic [OPT_NUM_W-1:0] send_option;
      logic [2:0]           local_state;
      logic [2:0]           remote_state;
   } rsp_type;

   // classified command, front to back
   typedef struct packed {
      cmd_kind_type         kind;
      logic                 remote;
      logic                 to_yes;
      logic                 in_range;
      logic [OPT_NUM_W-1:0] option;
      logic                 accepts;
      logic                 support;
   } cmd_type;

   typedef struct packed {
      neg_state_type local_st;
      neg_state_type remote_st;
      logic          supported;
   } entry_type;

endpackage

/* rtl/core/tonego_front.sv */
// ----------------------------------------------------------------------------
// tonego_front
// Accepts request beats, decodes the opcode into kind, side and direction,
// checks the option range and queues the classified command for the back.
// ----------------------------------------------------------------------------
module tonego_front (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  tonego_pkg::req_type req_data,
   output logic                q_valid,
   output tonego_pkg::cmd_type q_item,
   input  logic                q_pop
);
   import tonego_pkg::*;

   localparam logic [OPT_NUM_W:0] OPT_LIMIT = (OPT_NUM_W + 1)'(OPTION_COUNT);

   cmd_type           cls;
   cmd_type           q_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0] count_ff, count_in;
   logic              push;

   always_comb begin
      cls          = '0;
      cls.option   = req_data.option_number;
      cls.accepts  = req_data.handler_accepts;
      cls.support  = req_data.support_value;
      cls.in_range = ({1'b0, req_data.option_number} < OPT_LIMIT);
      case (opcode_type'(req_data.opcode))
         OP_RX_DO: begin
            cls.kind = K_RX;  cls.remote = 1'b0; cls.to_yes = 1'b1;
         end
         OP_RX_DONT: begin
            cls.kind = K_RX;  cls.remote = 1'b0; cls.to_yes = 1'b0;
         end
         OP_RX_WILL: begin
            cls.kind = K_RX;  cls.remote = 1'b1; cls.to_yes = 1'b1;
         end
         OP_RX_WONT: begin
            cls.kind = K_RX;  cls.remote = 1'b1; cls.to_yes = 1'b0;
         end
         OP_ASK_WILL: begin
            cls.kind = K_ASK; cls.remote = 1'b0; cls.to_yes = 1'b1;
         end
         OP_ASK_WONT: begin
            cls.kind = K_ASK; cls.remote = 1'b0; cls.to_yes = 1'b0;
         end
         OP_ASK_DO: begin
            cls.kind = K_ASK; cls.remote = 1'b1; cls.to_yes = 1'b1;
         end
         OP_ASK_DONT: begin
            cls.kind = K_ASK; cls.remote = 1'b1; cls.to_yes = 1'b0;
         end
         OP_SET_SUPPORT: begin
            cls.kind = K_SUPPORT;
         end
         default: begin
            cls.kind = K_NOP;
         end
      endcase
   end

   assign req_ready = (count_ff != QCNT_W'(QUEUE_DEPTH));
   assign push      = req_valid && req_ready;
   assign q_valid   = (count_ff != '0);
   assign q_item    = q_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (q_pop) begin
         rd_ptr_in = (rd_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !q_pop) begin
         count_in = count_ff + 1'b1;
      end else if (q_pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         q_ff[wr_ptr_ff] <= cls;
      end
   end

endmodule

/* rtl/core/tonego_back.sv */
// ----------------------------------------------------------------------------
// tonego_back
// Carries out queued commands: reads the option's table entry, applies the
// negotiation rules, writes the entry back and loads the response register.
// ----------------------------------------------------------------------------
module tonego_back (
   input  logic                clock,
   input  logic                reset,
   input  logic                q_valid,
   input  tonego_pkg::cmd_type q_item,
   output logic                q_pop,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output tonego_pkg::rsp_type rsp_data
);
   import tonego_pkg::*;

   back_state_type          state_ff, state_in;
   cmd_type                 cur_ff;
   entry_type               rd_ff;
   logic                    rdv_ff;
   logic [OPTION_COUNT-1:0] valid_ff;
   entry_type               mem [OPTION_COUNT];
   logic                    rsp_valid_ff, rsp_valid_in;
   rsp_type                 rsp_ff, rsp_in;

   logic                    exec_fire;
   logic [OPT_IDX_W-1:0]    rd_idx;
   logic [OPT_IDX_W-1:0]    wr_idx;
   entry_type               cur_entry;
   entry_type               new_entry;
   neg_state_type           sel_st;
   neg_state_type           new_st;
   neg_state_type           asked;
   send_cmd_type            yes_cmd;
   send_cmd_type            no_cmd;
   send_cmd_type            cmd;
   logic                    send;
   logic                    go_yes;

   assign rd_idx = q_item.option[OPT_IDX_W-1:0];
   assign wr_idx = cur_ff.option[OPT_IDX_W-1:0];

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         BK_IDLE: begin
            if (q_valid) begin
               state_in = BK_EXEC;
            end
         end
         BK_EXEC: begin
            if (exec_fire) begin
               state_in = BK_IDLE;
            end
         end
         default: begin
            state_in = BK_IDLE;
         end
      endcase
   end

   // fsm outputs
   always_comb begin
      q_pop     = 1'b0;
      exec_fire = 1'b0;
      case (state_ff)
         BK_IDLE: begin
            q_pop = q_valid;
         end
         BK_EXEC: begin
            exec_fire = !rsp_valid_ff || rsp_ready;
         end
         default: begin
            q_pop = 1'b0;
         end
      endcase
   end

   // negotiation rules on the entry just read
   always_comb begin
      cur_entry = rdv_ff ? rd_ff : entry_type'('0);
      sel_st    = cur_ff.remote ? cur_entry.remote_st : cur_entry.local_st;
      yes_cmd   = cur_ff.remote ? CMD_DO : CMD_WILL;
      no_cmd    = cur_ff.remote ? CMD_DONT : CMD_WONT;
      asked     = cur_ff.to_yes ? NS_YES : NS_NO;
      go_yes    = cur_ff.to_yes ? cur_ff.accepts : !cur_ff.accepts;
      new_st    = sel_st;
      send      = 1'b0;
      cmd       = CMD_WILL;
      new_entry = cur_entry;
      case (cur_ff.kind)
         K_RX: begin
            if (sel_st != asked) begin
               if (!cur_entry.supported) begin
                  // refuse once, only from none
                  if (sel_st == NS_NONE) begin
                     send   = 1'b1;
                     cmd    = no_cmd;
                     new_st = NS_NO;
                  end
               end else if (go_yes) begin
                  send   = (sel_st != NS_WANT_YES);
                  cmd    = yes_cmd;
                  new_st = NS_YES;
               end else begin
                  send   = (sel_st != NS_WANT_NO);
                  cmd    = no_cmd;
                  new_st = NS_NO;
               end
            end
         end
         K_ASK: begin
            if (cur_ff.to_yes) begin
               if (sel_st != NS_YES && sel_st != NS_WANT_YES) begin
                  send   = 1'b1;
                  cmd    = yes_cmd;
                  new_st = NS_WANT_YES;
               end
            end else begin
               if (sel_st != NS_NO && sel_st != NS_WANT_NO) begin
                  send   = 1'b1;
                  cmd    = no_cmd;
                  new_st = NS_WANT_NO;
               end
            end
         end
         K_SUPPORT: begin
            new_entry.supported = cur_ff.support;
         end
         default: begin
            send = 1'b0;
         end
      endcase
      if (cur_ff.kind == K_RX || cur_ff.kind == K_ASK) begin
         if (cur_ff.remote) begin
            new_entry.remote_st = new_st;
         end else begin
            new_entry.local_st = new_st;
         end
      end

      rsp_in = '0;
      if (cur_ff.in_range) begin
         rsp_in.send_valid   = send;
         rsp_in.send_command = send ? cmd : CMD_WILL;
         rsp_in.send_option  = send ? cur_ff.option : '0;
         rsp_in.local_state  = new_entry.local_st;
         rsp_in.remote_state = new_entry.remote_st;
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (exec_fire) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= BK_IDLE;
         rsp_valid_ff <= 1'b0;
         valid_ff     <= '0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         if (exec_fire && cur_ff.in_range) begin
            valid_ff[wr_idx] <= 1'b1;
         end
      end
   end

   // table memory: one read port, one write port
   always_ff @(posedge clock) begin
      if (q_pop) begin
         rd_ff  <= mem[rd_idx];
         rdv_ff <= valid_ff[rd_idx];
         cur_ff <= q_item;
      end
      if (exec_fire && cur_ff.in_range) begin
         mem[wr_idx] <= new_entry;
      end
      if (exec_fire) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

/* rtl/core/telnet_option_negotiator.sv */
// ----------------------------------------------------------------------------
// telnet_option_negotiator
// Per-option telnet negotiation state keeper: local and remote side state and
// a supported bit for each option code, one response beat per request beat.
//
//   channel  dir  handshake              beat
//   req_     in   req_valid/req_ready    req_data  (tonego_pkg::req_type)
//   rsp_     out  rsp_valid/rsp_ready    rsp_data  (tonego_pkg::rsp_type)
//
// In the back end, BK_IDLE reads the option's table entry and BK_EXEC
// updates it and loads the response register.
// The back end carries out requests one at a time.
// A 2-entry command queue takes requests while the back end works.
// Reset clears the per-entry valid bits at once; no clearing pass follows.
// A stalled response holds the back end; the queue then fills and drops
// req_ready.
// ----------------------------------------------------------------------------
module telnet_option_negotiator (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  tonego_pkg::req_type req_data,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output tonego_pkg::rsp_type rsp_data
);
   import tonego_pkg::*;

   logic    q_valid;
   logic    q_pop;
   cmd_type q_item;

   tonego_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .q_valid   (q_valid),
      .q_item    (q_item),
      .q_pop     (q_pop)
   );

   tonego_back u_back (
      .clock     (clock),
      .reset     (reset),
      .q_valid   (q_valid),
      .q_item    (q_item),
      .q_pop     (q_pop),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

endmodule

/* rtl/core/tonego_checker.sv */
// ----------------------------------------------------------------------------
// tonego_checker
// Port-level checks on the negotiator, attached to the top level by bind.
// ----------------------------------------------------------------------------
module tonego_checker (
   input logic                clock,
   input logic                reset,
   input logic                rsp_valid,
   input logic                rsp_ready,
   input tonego_pkg::rsp_type rsp_data
);
   import tonego_pkg::*;

   // a stalled response beat holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("response beat changed while stalled");

   // nothing comes out right after reset
   a_rsp_reset: assert property (@(posedge clock)
      !reset && $past(reset) |-> !rsp_valid)
      else $error("response valid right after reset");

   // no command means zero command fields
   a_quiet_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.send_valid |->
         rsp_data.send_command == 2'd0 && rsp_data.send_option == '0)
      else $error("command fields set without a command");

   // a sent WILL leaves the local side at yes or heading there
   a_will_state: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.send_valid && rsp_data.send_command == CMD_WILL |->
         rsp_data.local_state == NS_YES || rsp_data.local_state == NS_WANT_YES)
      else $error("WILL sent with local side not at yes");

   // a sent DONT leaves the remote side at no or heading there
   a_dont_state: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.send_valid && rsp_data.send_command == CMD_DONT |->
         rsp_data.remote_state == NS_NO || rsp_data.remote_state == NS_WANT_NO)
      else $error("DONT sent with remote side not at no");

endmodule

bind telnet_option_negotiator tonego_checker u_tonego_checker (
   .clock     (clock),
   .reset     (reset),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_data  (rsp_data)
);

/* sim/telnet_option_negotiator_tb.sv */
// ----------------------------------------------------------------------------
// telnet_option_negotiator_tb
// Self-checking bench for the telnet option negotiator. A directed sequence
// walks the negotiation corners on a few option codes. Random traffic, mostly
// on a small set of busy options, follows, first with a slow receiver, then
// with a slow sender, then at full rate. Every response beat is checked
// field by field against a local model of the per-option state tables.
// ----------------------------------------------------------------------------
module telnet_option_negotiator_tb;
   import tonego_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int         QUIET_LIMIT  = 3000;
   localparam int         DRAIN_CYCLES = 10;
   localparam logic [3:0] OP_UNUSED_LO = 4'd9;
   localparam logic [3:0] OP_UNUSED_HI = 4'd15;

   logic    clock     = 1'b0;
   logic    reset     = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_ready;
   req_type req_data  = '0;
   logic    rsp_valid;
   logic    rsp_ready = 1'b0;
   rsp_type rsp_data;

   // model of the option tables
   neg_state_type local_neg [256];
   neg_state_type remote_neg [256];
   logic          opt_supported [256];

   rsp_type pending_replies [$];
   int      mismatch_count    = 0;
   int      quiet_cycles      = 0;
   int      sender_idle_pct   = 0;
   int      receiver_idle_pct = 0;

   logic [7:0] busy_options [8] = '{8'd0, 8'd1, 8'd3, 8'd24, 8'd31, 8'd128, 8'd200, 8'd255};

   telnet_option_negotiator i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   always #5 clock = ~clock;

   // expected response for one request, with the table update
   function automatic rsp_type negotiate(req_type r);
      neg_state_type st;
      neg_state_type asked;
      send_cmd_type  cmd;
      send_cmd_type  yes_cmd;
      send_cmd_type  no_cmd;
      logic          on_remote;
      logic          want_yes;
      logic          go_yes;
      logic          send;
      logic [7:0]    idx;
      rsp_type       o;
      o    = '0;
      send = 1'b0;
      cmd  = CMD_WILL;
      idx  = r.option_number;
      if (int'(idx) >= OPTION_COUNT) begin
         return o;
      end
      on_remote = (r.opcode == OP_RX_WILL) || (r.opcode == OP_RX_WONT) ||
                  (r.opcode == OP_ASK_DO) || (r.opcode == OP_ASK_DONT);
      st        = on_remote ? remote_neg[idx] : local_neg[idx];
      yes_cmd   = on_remote ? CMD_DO : CMD_WILL;
      no_cmd    = on_remote ? CMD_DONT : CMD_WONT;
      case (r.opcode)
         OP_RX_DO, OP_RX_DONT, OP_RX_WILL, OP_RX_WONT: begin
            want_yes = (r.opcode == OP_RX_DO) || (r.opcode == OP_RX_WILL);
            asked    = want_yes ? NS_YES : NS_NO;
            if (st != asked) begin
               if (!opt_supported[idx]) begin
                  // refuse once, only from none
                  if (st == NS_NONE) begin
                     send = 1'b1;
                     cmd  = no_cmd;
                     st   = NS_NO;
                  end
               end else begin
                  go_yes = want_yes ? r.handler_accepts : !r.handler_accepts;
                  if (go_yes) begin
                     if (st != NS_WANT_YES) begin
                        send = 1'b1;
                        cmd  = yes_cmd;
                     end
                     st = NS_YES;
                  end else begin
                     if (st != NS_WANT_NO) begin
                        send = 1'b1;
                        cmd  = no_cmd;
                     end
                     st = NS_NO;
                  end
               end
            end
         end
         OP_ASK_WILL, OP_ASK_DO: begin
            if (st != NS_YES && st != NS_WANT_YES) begin
               st   = NS_WANT_YES;
               send = 1'b1;
               cmd  = yes_cmd;
            end
         end
         OP_ASK_WONT, OP_ASK_DONT: begin
            if (st != NS_NO && st != NS_WANT_NO) begin
               st   = NS_WANT_NO;
               send = 1'b1;
               cmd  = no_cmd;
            end
         end
         OP_SET_SUPPORT: begin
            opt_supported[idx] = r.support_value;
         end
         default: begin
         end
      endcase
      if (on_remote) begin
         remote_neg[idx] = st;
      end else begin
         local_neg[idx] = st;
      end
      if (send) begin
         o.send_valid   = 1'b1;
         o.send_command = cmd;
         o.send_option  = r.option_number;
      end
      o.local_state  = local_neg[idx];
      o.remote_state = remote_neg[idx];
      return o;
   endfunction

   task automatic report_mismatch(string what);
      $display("%0t mismatch: %s", $time, what);
      mismatch_count++;
   endtask

   // response check first, then queue the prediction for a new request beat
   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_replies.size() == 0) begin
            report_mismatch($sformatf("unexpected response %h", rsp_data));
         end else begin
            want = pending_replies.pop_front();
            if (rsp_data.send_valid !== want.send_valid)
               report_mismatch($sformatf("send_valid %b want %b",
                                         rsp_data.send_valid, want.send_valid));
            if (rsp_data.send_command !== want.send_command)
               report_mismatch($sformatf("send_command %0d want %0d",
                                         rsp_data.send_command, want.send_command));
            if (rsp_data.send_option !== want.send_option)
               report_mismatch($sformatf("send_option %0d want %0d",
                                         rsp_data.send_option, want.send_option));
            if (rsp_data.local_state !== want.local_state)
               report_mismatch($sformatf("local_state %0d want %0d",
                                         rsp_data.local_state, want.local_state));
            if (rsp_data.remote_state !== want.remote_state)
               report_mismatch($sformatf("remote_state %0d want %0d",
                                         rsp_data.remote_state, want.remote_state));
         end
      end
      if (!reset && req_valid && req_ready) begin
         pending_replies.push_back(negotiate(req_data));
      end
   end

   // receiver back-pressure
   always @(negedge clock) begin
      rsp_ready <= ($urandom_range(99) >= receiver_idle_pct);
   end

   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
      if (quiet_cycles >= QUIET_LIMIT) begin
         $display("RESULT: ERROR");
         $finish;
      end
   end

   function automatic req_type make_req(logic [3:0] op, logic [7:0] opt,
                                        logic acc, logic sup);
      req_type r;
      r.opcode          = op;
      r.option_number   = opt;
      r.handler_accepts = acc;
      r.support_value   = sup;
      return r;
   endfunction

   // one request beat; valid stays high into the next call unless a gap is drawn
   task automatic send_req(req_type r);
      @(negedge clock);
      while ($urandom_range(99) < sender_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= r;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
   endtask

   task automatic wait_drained();
      while (pending_replies.size() != 0) @(posedge clock);
   endtask

   task automatic run_random(int count);
      logic [3:0] op;
      logic [7:0] opt;
      repeat (count) begin
         if ($urandom_range(99) < 4) begin
            op = 4'($urandom_range(OP_UNUSED_HI, OP_UNUSED_LO));
         end else if ($urandom_range(99) < 12) begin
            op = OP_SET_SUPPORT;
         end else begin
            op = 4'($urandom_range(OP_ASK_DONT, OP_RX_DO));
         end
         if ($urandom_range(99) < 75) begin
            opt = busy_options[3'($urandom_range(7))];
         end else begin
            opt = 8'($urandom_range(255));
         end
         send_req(make_req(op, opt, 1'($urandom_range(1)), 1'($urandom_range(1))));
      end
      @(negedge clock);
      req_valid <= 1'b0;
      wait_drained();
   endtask

   task automatic test_directed_cases();
      sender_idle_pct   = 20;
      receiver_idle_pct = 20;
      // asking for off from none still sends the refusal
      send_req(make_req(OP_ASK_WONT, 8'd0, 1'b0, 1'b0));
      send_req(make_req(OP_ASK_DONT, 8'd0, 1'b0, 1'b0));
      send_req(make_req(OP_RX_DONT, 8'd0, 1'b1, 1'b1));
      send_req(make_req(OP_RX_WONT, 8'd0, 1'b0, 1'b0));
      // supported option walks through the handler answers
      send_req(make_req(OP_SET_SUPPORT, 8'd255, 1'b0, 1'b1));
      send_req(make_req(OP_RX_DO, 8'd255, 1'b1, 1'b0));
      send_req(make_req(OP_RX_DO, 8'd255, 1'b1, 1'b0));
      send_req(make_req(OP_RX_WILL, 8'd255, 1'b0, 1'b0));
      send_req(make_req(OP_ASK_WILL, 8'd255, 1'b0, 1'b0));
      send_req(make_req(OP_ASK_WONT, 8'd255, 1'b0, 1'b0));
      send_req(make_req(OP_RX_DONT, 8'd255, 1'b1, 1'b0));
      send_req(make_req(OP_ASK_DO, 8'd255, 1'b0, 1'b0));
      send_req(make_req(OP_RX_WILL, 8'd255, 1'b1, 1'b0));
      send_req(make_req(OP_ASK_DONT, 8'd255, 1'b0, 1'b0));
      send_req(make_req(OP_RX_WONT, 8'd255, 1'b0, 1'b0));
      // unsupported option refuses once
      send_req(make_req(OP_RX_DO, 8'd1, 1'b1, 1'b1));
      send_req(make_req(OP_RX_WILL, 8'd1, 1'b1, 1'b1));
      send_req(make_req(OP_RX_DO, 8'd1, 1'b1, 1'b1));
      // unused opcodes only report the states
      send_req(make_req(OP_UNUSED_LO, 8'd255, 1'b0, 1'b0));
      send_req(make_req(OP_UNUSED_HI, 8'd255, 1'b1, 1'b1));
      send_req(make_req(OP_SET_SUPPORT, 8'd255, 1'b1, 1'b0));
      send_req(make_req(OP_RX_DONT, 8'd255, 1'b0, 1'b1));
      @(negedge clock);
      req_valid <= 1'b0;
      wait_drained();
   endtask

   task automatic test_random_slow_receiver();
      sender_idle_pct   = 36;
      receiver_idle_pct = 83;
      run_random(460);
   endtask

   task automatic test_random_slow_sender();
      sender_idle_pct   = 83;
      receiver_idle_pct = 36;
      run_random(460);
   endtask

   task automatic test_random_full_rate();
      sender_idle_pct   = 0;
      receiver_idle_pct = 0;
      run_random(480);
   endtask

   initial begin
      foreach (local_neg[i]) begin
         local_neg[i]     = NS_NONE;
         remote_neg[i]    = NS_NONE;
         opt_supported[i] = 1'b0;
      end
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      test_directed_cases();
      test_random_slow_receiver();
      test_random_slow_sender();
      test_random_full_rate();
      wait_drained();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule
